// File: rtl/core/tcc_pkg.sv
// Shared types and constants for the triangle circumcircle core.
// Holds the status codes and the control word that travels with each item.
// No dependencies.
package tcc_pkg;

   // Result status codes, carried on the response tuser.
   typedef enum logic [1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_COLLINEAR = 2'd1,
      STATUS_TOO_SMALL = 2'd2
   } status_type;

   // Width of the parent radius and of the minimum radius register.
   localparam int RADIUS_WIDTH = 24;

   // Minimum splittable radius after reset, in whole units.
   localparam int MIN_RADIUS_UNITS = 30;

   // Control word that moves from cell to cell along with the payload.
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       neg_x;
      logic       neg_y;
      logic       ovf_x;
      logic       ovf_y;
   } ctl_type;

endpackage

// File: rtl/core/tcc_front.sv
// Front pipeline of the circumcircle core: differences, products, numerators
// and the divider operands. Eight elastic stages.
// Depends on tcc_pkg.
module tcc_front #(
   parameter int W = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tcc_pkg::RADIUS_WIDTH-1:0]    min_radius,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [W-1:0]                 in_ax,
   input  logic signed [W-1:0]                 in_ay,
   input  logic signed [W-1:0]                 in_bx,
   input  logic signed [W-1:0]                 in_by,
   input  logic signed [W-1:0]                 in_cx,
   input  logic signed [W-1:0]                 in_cy,
   input  logic [tcc_pkg::RADIUS_WIDTH-1:0]    in_parent_radius,
   input  logic                                out_ready,
   output tcc_pkg::ctl_type                    out_ctl,
   output logic [2*W+4:0]                      out_dd,
   output logic [2*W+4:0]                      out_rem_x,
   output logic [2*W+4:0]                      out_rem_y,
   output logic [W+1:0]                        out_nq_x,
   output logic [W+1:0]                        out_nq_y,
   output logic [2*W-1:0]                      out_side
);

   localparam int DW  = W + 1;
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 1;
   localparam int GW  = PW + 1;
   localparam int LH  = SW / 2;
   localparam int HW  = SW - LH;
   localparam int PLW = DW + LH + 1;
   localparam int PHW = DW + HW + 1;
   localparam int NW  = DW + SW + 1;
   localparam int NNW = NW + 1;
   localparam int DDW = GW + 2;
   localparam int QB  = W + 2;
   localparam int NST = 8;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_ff_in;
   logic [NST-1:0] v_src;
   logic [NST:0]   adv;

   // Stage registers.
   logic signed [DW-1:0]  s1_a, s1_b, s1_c, s1_d;
   logic signed [W-1:0]   s1_ax, s1_ay;
   logic                  s1_small;
   logic signed [PW-1:0]  s2_aa, s2_bb, s2_cc, s2_dd, s2_ad, s2_bc;
   logic signed [DW-1:0]  s2_a, s2_b, s2_c, s2_d;
   logic signed [W-1:0]   s2_ax, s2_ay;
   logic                  s2_small;
   logic signed [SW-1:0]  s3_s1, s3_s2;
   logic signed [GW-1:0]  s3_g;
   logic signed [DW-1:0]  s3_a, s3_b, s3_c, s3_d;
   logic signed [W-1:0]   s3_ax, s3_ay;
   logic                  s3_small;
   logic signed [PLW-1:0] s4_ds1l, s4_bs2l, s4_as2l, s4_cs1l;
   logic signed [PHW-1:0] s4_ds1h, s4_bs2h, s4_as2h, s4_cs1h;
   logic signed [GW-1:0]  s4_g;
   logic signed [W-1:0]   s4_ax, s4_ay;
   logic                  s4_small;
   logic signed [NW-1:0]  s5_nx, s5_ny;
   logic signed [GW:0]    s5_g2;
   logic signed [W-1:0]   s5_ax, s5_ay;
   tcc_pkg::status_type   s5_status;
   logic [NW-1:0]         s6_mx, s6_my;
   logic [GW:0]           s6_mg;
   logic                  s6_neg_x, s6_neg_y;
   logic signed [W-1:0]   s6_ax, s6_ay;
   tcc_pkg::status_type   s6_status;
   logic [NNW-1:0]        s7_nx, s7_ny;
   logic [DDW-1:0]        s7_dd;
   logic                  s7_neg_x, s7_neg_y;
   logic signed [W-1:0]   s7_ax, s7_ay;
   tcc_pkg::status_type   s7_status;
   logic [DDW-1:0]        s8_dd, s8_rem_x, s8_rem_y;
   logic [QB-1:0]         s8_nq_x, s8_nq_y;
   logic                  s8_neg_x, s8_neg_y, s8_ovf_x, s8_ovf_y;
   logic signed [W-1:0]   s8_ax, s8_ay;
   tcc_pkg::status_type   s8_status;

   // Numerator combination, stage five.
   logic signed [PHW:0]   hd_x, hd_y;
   logic signed [PLW:0]   ld_x, ld_y;
   logic signed [NW-1:0]  nx_c, ny_c;

   // A stage advances when it is empty or the next one advances.
   always_comb begin
      adv[NST] = out_ready;
      for (int i = NST - 1; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign v_src    = {v_ff[NST-2:0], in_valid};
   assign v_ff_in  = (adv[NST-1:0] & v_src) | (~adv[NST-1:0] & v_ff);
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_ff_in;
      end
   end

   // Stage one: offsets from the first vertex and the parent radius check.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_a     <= DW'(in_bx) - DW'(in_ax);
         s1_b     <= DW'(in_by) - DW'(in_ay);
         s1_c     <= DW'(in_cx) - DW'(in_ax);
         s1_d     <= DW'(in_cy) - DW'(in_ay);
         s1_ax    <= in_ax;
         s1_ay    <= in_ay;
         s1_small <= in_parent_radius < min_radius;
      end
   end

   // Stage two: the six products of the offsets.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_aa    <= PW'(s1_a) * PW'(s1_a);
         s2_bb    <= PW'(s1_b) * PW'(s1_b);
         s2_cc    <= PW'(s1_c) * PW'(s1_c);
         s2_dd    <= PW'(s1_d) * PW'(s1_d);
         s2_ad    <= PW'(s1_a) * PW'(s1_d);
         s2_bc    <= PW'(s1_b) * PW'(s1_c);
         s2_a     <= s1_a;
         s2_b     <= s1_b;
         s2_c     <= s1_c;
         s2_d     <= s1_d;
         s2_ax    <= s1_ax;
         s2_ay    <= s1_ay;
         s2_small <= s1_small;
      end
   end

   // Stage three: squared lengths and the determinant.
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_s1    <= SW'(s2_aa) + SW'(s2_bb);
         s3_s2    <= SW'(s2_cc) + SW'(s2_dd);
         s3_g     <= GW'(s2_ad) - GW'(s2_bc);
         s3_a     <= s2_a;
         s3_b     <= s2_b;
         s3_c     <= s2_c;
         s3_d     <= s2_d;
         s3_ax    <= s2_ax;
         s3_ay    <= s2_ay;
         s3_small <= s2_small;
      end
   end

   // Stage four: partial products of offsets and split squared lengths.
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_ds1l  <= PLW'(s3_d) * PLW'($signed({1'b0, s3_s1[LH-1:0]}));
         s4_bs2l  <= PLW'(s3_b) * PLW'($signed({1'b0, s3_s2[LH-1:0]}));
         s4_as2l  <= PLW'(s3_a) * PLW'($signed({1'b0, s3_s2[LH-1:0]}));
         s4_cs1l  <= PLW'(s3_c) * PLW'($signed({1'b0, s3_s1[LH-1:0]}));
         s4_ds1h  <= PHW'(s3_d) * PHW'($signed({1'b0, s3_s1[SW-1:LH]}));
         s4_bs2h  <= PHW'(s3_b) * PHW'($signed({1'b0, s3_s2[SW-1:LH]}));
         s4_as2h  <= PHW'(s3_a) * PHW'($signed({1'b0, s3_s2[SW-1:LH]}));
         s4_cs1h  <= PHW'(s3_c) * PHW'($signed({1'b0, s3_s1[SW-1:LH]}));
         s4_g     <= s3_g;
         s4_ax    <= s3_ax;
         s4_ay    <= s3_ay;
         s4_small <= s3_small;
      end
   end

   // Recombine the partial products into the two numerators.
   always_comb begin
      hd_x = (PHW+1)'(s4_ds1h) - (PHW+1)'(s4_bs2h);
      ld_x = (PLW+1)'(s4_ds1l) - (PLW+1)'(s4_bs2l);
      hd_y = (PHW+1)'(s4_as2h) - (PHW+1)'(s4_cs1h);
      ld_y = (PLW+1)'(s4_as2l) - (PLW+1)'(s4_cs1l);
      nx_c = (NW'(hd_x) <<< LH) + NW'(ld_x);
      ny_c = (NW'(hd_y) <<< LH) + NW'(ld_y);
   end

   // Stage five: numerators, doubled determinant and the status.
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_nx <= nx_c;
         s5_ny <= ny_c;
         s5_g2 <= {s4_g, 1'b0};
         s5_ax <= s4_ax;
         s5_ay <= s4_ay;
         if (s4_small) begin
            s5_status <= tcc_pkg::STATUS_TOO_SMALL;
         end else if (s4_g == '0) begin
            s5_status <= tcc_pkg::STATUS_COLLINEAR;
         end else begin
            s5_status <= tcc_pkg::STATUS_VALID;
         end
      end
   end

   // Stage six: magnitudes and quotient signs.
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_mx     <= s5_nx[NW-1] ? NW'(-s5_nx) : NW'(s5_nx);
         s6_my     <= s5_ny[NW-1] ? NW'(-s5_ny) : NW'(s5_ny);
         s6_mg     <= s5_g2[GW] ? (GW+1)'(-s5_g2) : (GW+1)'(s5_g2);
         s6_neg_x  <= s5_nx[NW-1] ^ s5_g2[GW];
         s6_neg_y  <= s5_ny[NW-1] ^ s5_g2[GW];
         s6_ax     <= s5_ax;
         s6_ay     <= s5_ay;
         s6_status <= s5_status;
      end
   end

   // Stage seven: rounding bias folded into the dividend.
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_nx     <= NNW'({s6_mx, 1'b0}) + NNW'(s6_mg);
         s7_ny     <= NNW'({s6_my, 1'b0}) + NNW'(s6_mg);
         s7_dd     <= {s6_mg, 1'b0};
         s7_neg_x  <= s6_neg_x;
         s7_neg_y  <= s6_neg_y;
         s7_ax     <= s6_ax;
         s7_ay     <= s6_ay;
         s7_status <= s6_status;
      end
   end

   // Stage eight: initial remainders and quotient overflow detection.
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s8_dd     <= s7_dd;
         s8_rem_x  <= DDW'(s7_nx[NNW-1:QB]);
         s8_rem_y  <= DDW'(s7_ny[NNW-1:QB]);
         s8_ovf_x  <= DDW'(s7_nx[NNW-1:QB]) >= s7_dd;
         s8_ovf_y  <= DDW'(s7_ny[NNW-1:QB]) >= s7_dd;
         s8_nq_x   <= s7_nx[QB-1:0];
         s8_nq_y   <= s7_ny[QB-1:0];
         s8_neg_x  <= s7_neg_x;
         s8_neg_y  <= s7_neg_y;
         s8_ax     <= s7_ax;
         s8_ay     <= s7_ay;
         s8_status <= s7_status;
      end
   end

   // Hand the operands to the first divider cell.
   always_comb begin
      out_ctl.valid  = v_ff[NST-1];
      out_ctl.status = s8_status;
      out_ctl.neg_x  = s8_neg_x;
      out_ctl.neg_y  = s8_neg_y;
      out_ctl.ovf_x  = s8_ovf_x;
      out_ctl.ovf_y  = s8_ovf_y;
   end

   assign out_dd    = s8_dd;
   assign out_rem_x = s8_rem_x;
   assign out_rem_y = s8_rem_y;
   assign out_nq_x  = s8_nq_x;
   assign out_nq_y  = s8_nq_y;
   assign out_side  = {s8_ay, s8_ax};

endmodule

// File: rtl/core/tcc_div_cell.sv
// One cell of the divider chain: a restoring step on both quotients.
// Each cell yields one quotient bit per axis and hands on to its neighbor.
// Depends on tcc_pkg.
module tcc_div_cell #(
   parameter int DDW = 53,
   parameter int QB  = 26,
   parameter int SBW = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  tcc_pkg::ctl_type in_ctl,
   output logic             in_ready,
   input  logic [DDW-1:0]   in_dd,
   input  logic [DDW-1:0]   in_rem_x,
   input  logic [DDW-1:0]   in_rem_y,
   input  logic [QB-1:0]    in_nq_x,
   input  logic [QB-1:0]    in_nq_y,
   input  logic [SBW-1:0]   in_side,
   input  logic             out_ready,
   output tcc_pkg::ctl_type out_ctl,
   output logic [DDW-1:0]   out_dd,
   output logic [DDW-1:0]   out_rem_x,
   output logic [DDW-1:0]   out_rem_y,
   output logic [QB-1:0]    out_nq_x,
   output logic [QB-1:0]    out_nq_y,
   output logic [SBW-1:0]   out_side
);

   tcc_pkg::ctl_type ctl_ff;
   logic [DDW-1:0]   dd_ff, rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [QB-1:0]    nq_x_ff, nq_y_ff, nq_x_in, nq_y_in;
   logic [SBW-1:0]   side_ff;
   logic [DDW:0]     t_x, t_y, dd_ext;
   logic             ge_x, ge_y;

   assign in_ready = !ctl_ff.valid || out_ready;

   // Shift in the next dividend bit and subtract the divisor where it fits.
   always_comb begin
      dd_ext   = {1'b0, in_dd};
      t_x      = {in_rem_x, in_nq_x[QB-1]};
      t_y      = {in_rem_y, in_nq_y[QB-1]};
      ge_x     = t_x >= dd_ext;
      ge_y     = t_y >= dd_ext;
      rem_x_in = ge_x ? DDW'(t_x - dd_ext) : t_x[DDW-1:0];
      rem_y_in = ge_y ? DDW'(t_y - dd_ext) : t_y[DDW-1:0];
      nq_x_in  = {in_nq_x[QB-2:0], ge_x};
      nq_y_in  = {in_nq_y[QB-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         dd_ff    <= in_dd;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         nq_x_ff  <= nq_x_in;
         nq_y_ff  <= nq_y_in;
         side_ff  <= in_side;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_dd    = dd_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_nq_x  = nq_x_ff;
   assign out_nq_y  = nq_y_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/core/tcc_sqrt_cell.sv
// One cell of the square root chain: one root bit per cell, digit by digit.
// Takes two radicand bits and passes remainder and partial root onward.
// Depends on tcc_pkg.
module tcc_sqrt_cell #(
   parameter int RB  = 25,
   parameter int SBW = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  tcc_pkg::ctl_type in_ctl,
   output logic             in_ready,
   input  logic [RB+1:0]    in_rem,
   input  logic [RB-1:0]    in_root,
   input  logic [2*RB-1:0]  in_sh,
   input  logic [SBW-1:0]   in_side,
   input  logic             out_ready,
   output tcc_pkg::ctl_type out_ctl,
   output logic [RB+1:0]    out_rem,
   output logic [RB-1:0]    out_root,
   output logic [2*RB-1:0]  out_sh,
   output logic [SBW-1:0]   out_side
);

   localparam int RMW = RB + 2;

   tcc_pkg::ctl_type ctl_ff;
   logic [RMW-1:0]   rem_ff, rem_in;
   logic [RB-1:0]    root_ff, root_in;
   logic [2*RB-1:0]  sh_ff, sh_in;
   logic [SBW-1:0]   side_ff;
   logic [RMW+1:0]   t, trial;
   logic             ge;

   assign in_ready = !ctl_ff.valid || out_ready;

   // Try the next root bit against the remainder.
   always_comb begin
      t       = {in_rem, in_sh[2*RB-1:2*RB-2]};
      trial   = (RMW+2)'({in_root, 2'b01});
      ge      = t >= trial;
      rem_in  = ge ? RMW'(t - trial) : RMW'(t);
      root_in = {in_root[RB-2:0], ge};
      sh_in   = {in_sh[2*RB-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sh_ff   <= sh_in;
         side_ff <= in_side;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_sh   = sh_ff;
   assign out_side = side_ff;

endmodule

// File: rtl/core/triangle_circumcircle_core.sv
// Top level of the triangle circumcircle core.
// Instantiates tcc_front, the tcc_div_cell and tcc_sqrt_cell chains; uses tcc_pkg.
//
//   channel   direction  tdata fields (low bit up)                   tuser
//   req_*     in         ax ay bx by_coord cx cy parent_radius        -
//   rsp_*     out        centre_x centre_y circle_radius              status
//   csr_*     in         min_radius (write only)                      -
//
// One triangle is taken every cycle unless a response stall has filled the pipeline.
// The pipeline has eight front stages, COORD_WIDTH+2 divider cells, three post
// stages, COORD_WIDTH+1 square root cells and the output register.
// The divider and square root chains each settle one bit per cell.
// Reset is synchronous; it clears the valid flags and control words and loads min_radius with its default.
// A stage holds only while it is full and its successor holds, so a stalled response only
// stalls the request side once the whole pipeline has filled.
module triangle_circumcircle_core #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                             clock,
   input  logic                                             reset,
   // Configuration write port.
   input  logic                                             csr_wen,
   input  logic [tcc_pkg::RADIUS_WIDTH-1:0]                 csr_wdata,
   // Request: ax, ay, bx, by_coord, cx, cy, parent_radius, zero fill.
   input  logic                                             req_tvalid,
   output logic                                             req_tready,
   input  logic [((6*COORD_WIDTH+tcc_pkg::RADIUS_WIDTH+7)/8)*8-1:0] req_tdata,
   // Response: centre_x, centre_y, circle_radius, zero fill.
   output logic                                             rsp_tvalid,
   input  logic                                             rsp_tready,
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]               rsp_tdata,
   // Response tuser: status.
   output logic [1:0]                                       rsp_tuser
);

   localparam int W     = COORD_WIDTH;
   localparam int RW    = tcc_pkg::RADIUS_WIDTH;
   localparam int RS_TW = ((3*W+7)/8)*8;
   localparam int DDW   = 2*W + 5;
   localparam int QB    = W + 2;
   localparam int RB    = W + 1;
   localparam int EW    = W + 3;
   localparam int SQW   = 2*W + 1;
   localparam int NPS   = 3;

   localparam logic [QB-1:0]        CAP_Q = {2'b01, {W{1'b0}}};
   localparam logic signed [EW-1:0] MAX_C = EW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [EW-1:0] MIN_C = ~MAX_C;

   // Configuration register.
   logic [RW-1:0] min_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_ff <= RW'(tcc_pkg::MIN_RADIUS_UNITS << FRAC_BITS);
      end else if (csr_wen) begin
         min_radius_ff <= csr_wdata;
      end
   end

   // Front pipeline.
   tcc_pkg::ctl_type dv_ctl   [QB+1];
   logic [DDW-1:0]   dv_dd    [QB+1];
   logic [DDW-1:0]   dv_rem_x [QB+1];
   logic [DDW-1:0]   dv_rem_y [QB+1];
   logic [QB-1:0]    dv_nq_x  [QB+1];
   logic [QB-1:0]    dv_nq_y  [QB+1];
   logic [2*W-1:0]   dv_side  [QB+1];
   logic [QB:0]      dv_rdy;

   tcc_front #(.W(W)) u_front (
      .clock            (clock),
      .reset            (reset),
      .min_radius       (min_radius_ff),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_ax            ($signed(req_tdata[W-1:0])),
      .in_ay            ($signed(req_tdata[2*W-1:W])),
      .in_bx            ($signed(req_tdata[3*W-1:2*W])),
      .in_by            ($signed(req_tdata[4*W-1:3*W])),
      .in_cx            ($signed(req_tdata[5*W-1:4*W])),
      .in_cy            ($signed(req_tdata[6*W-1:5*W])),
      .in_parent_radius (req_tdata[6*W+RW-1:6*W]),
      .out_ready        (dv_rdy[0]),
      .out_ctl          (dv_ctl[0]),
      .out_dd           (dv_dd[0]),
      .out_rem_x        (dv_rem_x[0]),
      .out_rem_y        (dv_rem_y[0]),
      .out_nq_x         (dv_nq_x[0]),
      .out_nq_y         (dv_nq_y[0]),
      .out_side         (dv_side[0])
   );

   // Divider chain, one quotient bit per cell.
   for (genvar k = 0; k < QB; k++) begin : g_div
      tcc_div_cell #(.DDW(DDW), .QB(QB), .SBW(2*W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (dv_ctl[k]),
         .in_ready  (dv_rdy[k]),
         .in_dd     (dv_dd[k]),
         .in_rem_x  (dv_rem_x[k]),
         .in_rem_y  (dv_rem_y[k]),
         .in_nq_x   (dv_nq_x[k]),
         .in_nq_y   (dv_nq_y[k]),
         .in_side   (dv_side[k]),
         .out_ready (dv_rdy[k+1]),
         .out_ctl   (dv_ctl[k+1]),
         .out_dd    (dv_dd[k+1]),
         .out_rem_x (dv_rem_x[k+1]),
         .out_rem_y (dv_rem_y[k+1]),
         .out_nq_x  (dv_nq_x[k+1]),
         .out_nq_y  (dv_nq_y[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // Post stages between the two chains.
   logic [NPS-1:0] p_v_ff, p_v_in, p_src;
   logic [NPS:0]   p_adv;
   logic [RB:0]    sq_rdy;

   logic [QB-1:0]          p1_qx, p1_qy;
   logic                   p1_neg_x, p1_neg_y;
   logic signed [W-1:0]    p1_ax, p1_ay;
   tcc_pkg::status_type    p1_status;
   logic signed [W-1:0]    p2_ox, p2_oy;
   logic [2*W-1:0]         p2_sqx, p2_sqy;
   logic                   p2_big;
   tcc_pkg::status_type    p2_status;
   logic [SQW-1:0]         p3_sum;
   logic signed [W-1:0]    p3_ox, p3_oy;
   logic                   p3_big;
   tcc_pkg::status_type    p3_status;
   logic signed [EW-1:0]   ex_x, ex_y, qx_s, qy_s;

   always_comb begin
      p_adv[NPS] = sq_rdy[0];
      for (int i = NPS - 1; i >= 0; i--) begin
         p_adv[i] = !p_v_ff[i] || p_adv[i+1];
      end
   end

   assign dv_rdy[QB] = p_adv[0];
   assign p_src      = {p_v_ff[NPS-2:0], dv_ctl[QB].valid};
   assign p_v_in     = (p_adv[NPS-1:0] & p_src) | (~p_adv[NPS-1:0] & p_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= '0;
      end else begin
         p_v_ff <= p_v_in;
      end
   end

   // First post stage: cap the quotients.
   always_ff @(posedge clock) begin
      if (p_adv[0]) begin
         p1_qx     <= (dv_ctl[QB].ovf_x || dv_nq_x[QB] > CAP_Q) ? CAP_Q : dv_nq_x[QB];
         p1_qy     <= (dv_ctl[QB].ovf_y || dv_nq_y[QB] > CAP_Q) ? CAP_Q : dv_nq_y[QB];
         p1_neg_x  <= dv_ctl[QB].neg_x;
         p1_neg_y  <= dv_ctl[QB].neg_y;
         p1_ax     <= $signed(dv_side[QB][W-1:0]);
         p1_ay     <= $signed(dv_side[QB][2*W-1:W]);
         p1_status <= dv_ctl[QB].status;
      end
   end

   // Centre sums before clamping.
   always_comb begin
      qx_s = $signed({1'b0, p1_qx});
      qy_s = $signed({1'b0, p1_qy});
      ex_x = EW'(p1_ax) + (p1_neg_x ? -qx_s : qx_s);
      ex_y = EW'(p1_ay) + (p1_neg_y ? -qy_s : qy_s);
   end

   // Second post stage: clamp the centre and square the offsets.
   always_ff @(posedge clock) begin
      if (p_adv[1]) begin
         p2_ox     <= (ex_x > MAX_C) ? W'(MAX_C) : ((ex_x < MIN_C) ? W'(MIN_C) : W'(ex_x));
         p2_oy     <= (ex_y > MAX_C) ? W'(MAX_C) : ((ex_y < MIN_C) ? W'(MIN_C) : W'(ex_y));
         p2_sqx    <= (2*W)'(p1_qx[W-1:0]) * (2*W)'(p1_qx[W-1:0]);
         p2_sqy    <= (2*W)'(p1_qy[W-1:0]) * (2*W)'(p1_qy[W-1:0]);
         p2_big    <= (p1_qx[QB-1:W] != '0) || (p1_qy[QB-1:W] != '0);
         p2_status <= p1_status;
      end
   end

   // Third post stage: radicand.
   always_ff @(posedge clock) begin
      if (p_adv[2]) begin
         p3_sum    <= SQW'(p2_sqx) + SQW'(p2_sqy);
         p3_ox     <= p2_ox;
         p3_oy     <= p2_oy;
         p3_big    <= p2_big;
         p3_status <= p2_status;
      end
   end

   // Square root chain, one root bit per cell.
   tcc_pkg::ctl_type sq_ctl  [RB+1];
   logic [RB+1:0]    sq_rem  [RB+1];
   logic [RB-1:0]    sq_root [RB+1];
   logic [2*RB-1:0]  sq_sh   [RB+1];
   logic [2*W:0]     sq_side [RB+1];

   always_comb begin
      sq_ctl[0]        = '0;
      sq_ctl[0].valid  = p_v_ff[NPS-1];
      sq_ctl[0].status = p3_status;
   end

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_sh[0]   = (2*RB)'(p3_sum);
   assign sq_side[0] = {p3_big, p3_oy, p3_ox};

   for (genvar k = 0; k < RB; k++) begin : g_sqrt
      tcc_sqrt_cell #(.RB(RB), .SBW(2*W+1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (sq_ctl[k]),
         .in_ready  (sq_rdy[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_sh     (sq_sh[k]),
         .in_side   (sq_side[k]),
         .out_ready (sq_rdy[k+1]),
         .out_ctl   (sq_ctl[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_sh    (sq_sh[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // Output register: round the root, saturate and zero rejected items.
   logic                rsp_valid_ff;
   logic [W-1:0]        rsp_cx_ff, rsp_cy_ff, rsp_rad_ff, rad_c;
   tcc_pkg::status_type rsp_status_ff;
   logic [RB:0]         rnd;
   logic                ok;

   assign sq_rdy[RB] = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rnd = (sq_rem[RB] > (RB+2)'(sq_root[RB])) ? (RB+1)'(sq_root[RB]) + 1'b1
                                                : (RB+1)'(sq_root[RB]);
      rad_c = (sq_side[RB][2*W] || rnd[RB:W] != '0) ? {W{1'b1}} : rnd[W-1:0];
      ok    = sq_ctl[RB].status == tcc_pkg::STATUS_VALID;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sq_rdy[RB]) begin
         rsp_valid_ff <= sq_ctl[RB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_rdy[RB]) begin
         rsp_cx_ff     <= ok ? sq_side[RB][W-1:0] : '0;
         rsp_cy_ff     <= ok ? sq_side[RB][2*W-1:W] : '0;
         rsp_rad_ff    <= ok ? rad_c : '0;
         rsp_status_ff <= sq_ctl[RB].status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RS_TW'({rsp_rad_ff, rsp_cy_ff, rsp_cx_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/core/tcc_checker.sv
// Port-level checks for the triangle circumcircle core, bound to the top level.
// Depends on tcc_pkg and triangle_circumcircle_core.
module tcc_checker #(
   parameter int COORD_WIDTH = 24
) (
   input logic                                             clock,
   input logic                                             reset,
   input logic                                             csr_wen,
   input logic [tcc_pkg::RADIUS_WIDTH-1:0]                 csr_wdata,
   input logic                                             req_tvalid,
   input logic                                             req_tready,
   input logic [((6*COORD_WIDTH+tcc_pkg::RADIUS_WIDTH+7)/8)*8-1:0] req_tdata,
   input logic                                             rsp_tvalid,
   input logic                                             rsp_tready,
   input logic [((3*COORD_WIDTH+7)/8)*8-1:0]               rsp_tdata,
   input logic [1:0]                                       rsp_tuser
);

   // A rejected item carries zero centre and radius.
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != tcc_pkg::STATUS_VALID) |-> (rsp_tdata == '0))
      else $error("rejected item carries nonzero geometry");

   // A stalled response transfer holds its payload.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind triangle_circumcircle_core tcc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tcc_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for triangle_circumcircle_core.
// Drives triangles on the request stream, predicts the circumcircle in exact integer
// arithmetic and compares every response; depends on tcc_pkg and the core RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 24;
   localparam int MAX_HOLD = 300;
   localparam int SETTLE = 80;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic signed [CW-1:0] ax, ay, bx, by_c, cx, cy;
      logic [CW-1:0]        prad;
   } tri_type;

   typedef struct {
      logic signed [CW-1:0] ctr_x, ctr_y;
      logic [CW-1:0]        rad;
      tcc_pkg::status_type  status;
   } circle_type;

   // Predicts the circle for each accepted triangle and checks responses in order.
   class circle_scoreboard;
      circle_type    pending_q[$];
      logic [CW-1:0] min_radius;
      int errors, n_in, n_out, n_collinear, n_small, n_sat;

      function new();
         min_radius = CW'(tcc_pkg::MIN_RADIUS_UNITS << 8);
      endfunction

      // Rounded quotient magnitude, ties away from zero, capped.
      function logic [63:0] round_quot(logic signed [127:0] n, logic signed [127:0] d,
                                       output logic neg);
         logic [127:0] an, ad, q;
         an = n < 0 ? -n : n;
         ad = d < 0 ? -d : d;
         neg = (n < 0) != (d < 0);
         q = (2 * an + ad) / (2 * ad);
         if (q > (128'd1 << (CW + 1))) q = 128'd1 << (CW + 1);
         return q[63:0];
      endfunction

      function logic signed [CW-1:0] clamp(logic signed [63:0] v);
         if (v > 64'sd8388607) return 24'sh7FFFFF;
         if (v < -64'sd8388608) return 24'sh800000;
         return v[CW-1:0];
      endfunction

      function void note_input(tri_type t);
         logic signed [127:0] a, b, c, d, s1, s2, g, nx, ny;
         logic [127:0] s, rt, sq;
         logic [63:0] qx, qy;
         logic negx, negy;
         circle_type e;
         n_in++;
         e.ctr_x = '0; e.ctr_y = '0; e.rad = '0; e.status = tcc_pkg::STATUS_VALID;
         a = t.bx - t.ax; b = t.by_c - t.ay; c = t.cx - t.ax; d = t.cy - t.ay;
         g = a * d - b * c;
         if (t.prad < min_radius) begin
            e.status = tcc_pkg::STATUS_TOO_SMALL;
            n_small++;
         end else if (g == 0) begin
            e.status = tcc_pkg::STATUS_COLLINEAR;
            n_collinear++;
         end else begin
            g = 2 * g;
            s1 = a * a + b * b;
            s2 = c * c + d * d;
            nx = d * s1 - b * s2;
            ny = a * s2 - c * s1;
            qx = round_quot(nx, g, negx);
            qy = round_quot(ny, g, negy);
            e.ctr_x = clamp(t.ax + (negx ? -$signed(qx) : $signed(qx)));
            e.ctr_y = clamp(t.ay + (negy ? -$signed(qy) : $signed(qy)));
            if (qx >= (64'd1 << CW) || qy >= (64'd1 << CW)) begin
               e.rad = '1;
               n_sat++;
            end else begin
               // Bitwise square root, then round to nearest.
               s = qx * qx + qy * qy;
               rt = 0;
               for (int k = 33; k >= 0; k--) begin
                  sq = rt | (128'd1 << k);
                  if (sq * sq <= s) rt = sq;
               end
               if (s - rt * rt > rt) rt++;
               if (rt > (128'd1 << CW) - 1) rt = (128'd1 << CW) - 1;
               e.rad = rt[CW-1:0];
            end
         end
         pending_q.insert(pending_q.size(), e);
      endfunction

      function void check(circle_type r);
         circle_type e;
         n_out++;
         if (pending_q.size() == 0) begin
            $display("%0t: response with nothing expected: x %h y %h r %h st %0d",
                     $time, r.ctr_x, r.ctr_y, r.rad, r.status);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (r.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
            errors++;
         end
         if (r.ctr_x !== e.ctr_x) begin
            $display("%0t: centre_x expected %h actual %h", $time, e.ctr_x, r.ctr_x);
            errors++;
         end
         if (r.ctr_y !== e.ctr_y) begin
            $display("%0t: centre_y expected %h actual %h", $time, e.ctr_y, r.ctr_y);
            errors++;
         end
         if (r.rad !== e.rad) begin
            $display("%0t: circle_radius expected %h actual %h", $time, e.rad, r.rad);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_wen;
   logic [tcc_pkg::RADIUS_WIDTH-1:0] csr_wdata;
   logic req_tvalid, req_tready;
   logic [167:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   circle_scoreboard sb = new();
   bit quiet = 0;     // no idling on either side
   bit hold_rsp = 0;  // request a long receiver hold-off
   int idle_cycles = 0;

   triangle_circumcircle_core uut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Monitor both streams at the rising edge.
   always @(posedge clock) begin
      tri_type t;
      circle_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            {t.prad, t.cy, t.cx, t.by_c, t.bx, t.ay, t.ax} = req_tdata;
            sb.note_input(t);
         end
         if (rsp_tvalid && rsp_tready) begin
            {r.rad, r.ctr_y, r.ctr_x} = rsp_tdata;
            r.status = tcc_pkg::status_type'(rsp_tuser);
            sb.check(r);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stall bursts, stretches without stalls, and one long hold-off.
   initial begin
      int pct;
      pct = 20;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) pct = $urandom_range(0, 3) * 15;
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (MAX_HOLD) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(1, 100) <= pct) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Offer one triangle, possibly after an idle burst, and wait for its transfer.
   task automatic send_tri(tri_type t);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {t.prad, t.cy, t.cx, t.by_c, t.bx, t.ay, t.ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected response has arrived.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_min_radius(logic [CW-1:0] v);
      drain();
      @(negedge clock);
      csr_wen <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen <= 0;
      sb.min_radius = v;
   endtask

   function automatic logic [CW-1:0] rand_prad();
      if ($urandom_range(0, 9) < 8) return CW'($urandom_range(sb.min_radius, 24'hFFFFFF));
      return CW'($urandom);
   endfunction

   function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] base, int span);
      return base + CW'($urandom_range(0, 2 * span) - span);
   endfunction

   // Random triangle: mostly ordinary shapes, plus full-range, collinear and degenerate ones.
   function automatic tri_type rand_tri();
      tri_type t;
      int kind, dx, dy, k, m;
      kind = $urandom_range(0, 99);
      t.prad = rand_prad();
      if (kind < 55) begin
         t.cx = CW'($urandom_range(0, 1 << 18) - (1 << 17));
         t.cy = CW'($urandom_range(0, 1 << 18) - (1 << 17));
         t.ax = near(t.cx, 1 << 13); t.ay = near(t.cy, 1 << 13);
         t.bx = near(t.cx, 1 << 13); t.by_c = near(t.cy, 1 << 13);
      end else if (kind < 80) begin
         t.ax = CW'($urandom); t.ay = CW'($urandom); t.bx = CW'($urandom);
         t.by_c = CW'($urandom); t.cx = CW'($urandom); t.cy = CW'($urandom);
      end else if (kind < 90) begin
         dx = $urandom_range(0, 128) - 64; dy = $urandom_range(0, 128) - 64;
         k = $urandom_range(0, 2000) - 1000; m = $urandom_range(0, 2000) - 1000;
         t.ax = CW'($urandom_range(0, 1 << 21) - (1 << 20));
         t.ay = CW'($urandom_range(0, 1 << 21) - (1 << 20));
         t.bx = t.ax + CW'(k * dx); t.by_c = t.ay + CW'(k * dy);
         t.cx = t.ax + CW'(m * dx); t.cy = t.ay + CW'(m * dy);
      end else if (kind < 96) begin
         // Nearly collinear: one point nudged off a long line, huge centre.
         t.ax = CW'(-(1 << 22) + $urandom_range(0, 255)); t.ay = near(0, 1 << 20);
         t.bx = CW'((1 << 22) - $urandom_range(0, 255)); t.by_c = t.ay;
         t.cx = near(0, 1 << 16); t.cy = t.ay + CW'($urandom_range(1, 3));
      end else begin
         t.ax = CW'($urandom); t.ay = CW'($urandom);
         t.bx = t.ax; t.by_c = t.ay; t.cx = t.ax; t.cy = t.ay;
      end
      return t;
   endfunction

   function automatic tri_type mk(int ax, int ay, int bx, int by_c, int cx, int cy, int prad);
      tri_type t;
      t.ax = CW'(ax); t.ay = CW'(ay); t.bx = CW'(bx); t.by_c = CW'(by_c);
      t.cx = CW'(cx); t.cy = CW'(cy); t.prad = CW'(prad);
      return t;
   endfunction

   initial begin
      reset = 1;
      csr_wen = 0;
      csr_wdata = '0;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed triangles: ordinary, extremes, collinear, too small, saturation.
      send_tri(mk(0, 0, 256, 0, 0, 256, 24'hFFFFFF));
      send_tri(mk(-1280, 512, 2560, -768, 300, 40, 10000));
      send_tri(mk(8388607, 8388607, -8388608, 8388607, 8388607, -8388608, 24'hFFFFFF));
      send_tri(mk(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607, 7680));
      send_tri(mk(8388607, -8388608, -8388608, 8388607, 0, 0, 24'hFFFFFF));
      send_tri(mk(-8388608, 0, 8388607, 1, 0, -1, 24'hFFFFFF));
      send_tri(mk(-8388608, 0, 8388607, 0, 0, 1, 24'hFFFFFF));
      send_tri(mk(5, 5, 5, 5, 5, 5, 24'hFFFFFF));
      send_tri(mk(0, 0, 100, 100, 300, 300, 24'hFFFFFF));
      send_tri(mk(-8388608, -8388608, 0, 0, 8388607, 8388607, 24'hFFFFFF));
      send_tri(mk(0, 0, 256, 0, 0, 256, 7679));
      send_tri(mk(0, 0, 256, 0, 0, 256, 0));
      send_tri(mk(0, 0, 0, 0, 0, 0, 0));
      send_tri(mk(0, 0, 1, 0, 0, 1, 7680));
      send_tri(mk(0, 0, 3, 0, 0, 1, 7680));
      send_tri(mk(-1, -1, 1, -2, 2, 3, 8000));
      send_tri(mk(8388607, 8388607, 8388606, 8388607, 8388607, 8388606, 24'hFFFFFF));
      send_tri(mk(-8388608, -8388608, -8388607, -8388608, -8388608, -8388607, 30000));
      send_tri(mk(100, -8388608, 8388607, 100, -8388608, -8388608, 24'hFFFFFF));
      send_tri(mk(0, 0, 1, 1, 2, 3, 24'hFFFFFF));

      // Default minimum radius, with a long receiver hold-off in the middle.
      repeat (120) send_tri(rand_tri());
      hold_rsp = 1;
      repeat (150) send_tri(rand_tri());
      repeat (100) send_tri(rand_tri());

      write_min_radius('0);
      send_tri(mk(0, 0, 256, 0, 0, 256, 0));
      repeat (250) send_tri(rand_tri());

      write_min_radius(24'hFFFFFF);
      send_tri(mk(0, 0, 256, 0, 0, 256, 24'hFFFFFE));
      send_tri(mk(0, 0, 256, 0, 0, 256, 24'hFFFFFF));
      repeat (60) send_tri(rand_tri());

      write_min_radius(CW'($urandom_range(1, 1 << 20)));
      repeat (300) send_tri(rand_tri());

      write_min_radius(CW'(tcc_pkg::MIN_RADIUS_UNITS << 8));
      repeat (150) send_tri(rand_tri());
      quiet = 1;
      repeat (150) send_tri(rand_tri());
      drain();

      $display("Run covered %0d triangles and %0d responses under five minimum-radius settings.",
               sb.n_in, sb.n_out);
      $display("Outcomes: %0d collinear, %0d too small, %0d saturated radius.",
               sb.n_collinear, sb.n_small, sb.n_sat);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
